/* hw/rtl/npwr_pkg.sv */
// Package for the nearest point window replay block.
// Holds widths, mode codes, config indexes and the sequencer state type.
package npwr_pkg;
    localparam int TableDepthDef = 1024;
    localparam int MaxWindowDef  = 64;
    localparam int WinW          = 7;
    localparam int StepW         = 20;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic CFG_WIN  = 1'b0;
    localparam logic CFG_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_FETCH,
        ST_EMIT,
        ST_ERR
    } t_state;

    // one stored point, 320 bits
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] speed;
        logic [31:0] accel;
        logic [31:0] arc;
        logic [31:0] curv;
        logic [31:0] curv_rate;
        logic [31:0] time_v;
        logic [31:0] heading;
    } t_point;
endpackage

/* hw/rtl/nearest_point_window_replay.sv */
// Top level of the nearest point window replay block.
// Depends on npwr_pkg, npwr_table and npwr_dist.
//
//  group  dir  carries
//  s_axis in   tuser: mode[1:0]; tdata: pt_x pt_y pt_z pt_speed pt_accel pt_curv
//              pt_curv_rate pt_time pt_heading pt_arc (32 bits each, from bit 0)
//  m_axis out  tuser: ok; tlast: last; tdata: out_x .. out_arc (32 bits each)
//  cfg    in   index 0 window_len, 1 time_step
//
// Clear, append and ignored items are handled in the idle state. A query scans
// every stored point through the table read port and the two-stage distance
// unit, then reads and presents each result in turn (read, present).
// Reset is synchronous active low; it clears count and flag and loads the
// default window and step.
// Stalls on the output hold the result register; no input is taken meanwhile.
module nearest_point_window_replay import npwr_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int MAX_WINDOW  = MaxWindowDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [319:0] s_axis_tdata,   // pt_x, pt_y, pt_z, pt_speed, pt_accel,
                                         // pt_curv, pt_curv_rate, pt_time,
                                         // pt_heading, pt_arc
    input  logic [1:0]   s_axis_tuser,   // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [319:0] m_axis_tdata,   // out_x, out_y, out_z, out_speed, out_accel,
                                         // out_curv, out_curv_rate, out_time,
                                         // out_heading, out_arc
    output logic         m_axis_tuser,   // ok
    output logic         m_axis_tlast,   // last
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [WinW-1:0]  r_win;
    logic [StepW-1:0] r_step;
    logic [31:0] r_qx, r_qy;
    logic [CW-1:0] r_rd;      // scan read pointer
    logic [CW-1:0] r_cmp;     // index of distance now at unit output
    logic [2:0]    r_pipe;    // valid bits through read + two dist stages
    logic [64:0]   r_best_d;
    logic [CW-1:0] r_best;
    logic [WinW-1:0] r_k, r_wlim;
    logic [31:0] r_zero_t, r_t;
    logic          r_first;
    logic          r_ovalid, r_olast, r_ok;
    t_point        r_opt;
    logic [31:0]   r_ot;

    t_mode  in_mode;
    t_point in_pt, rd_pt;
    logic   in_acc, out_acc, we;
    logic [AW-1:0] raddr;
    logic [64:0] d2;
    logic [CW-1:0] avail, idx;

    assign in_mode = t_mode'(s_axis_tuser);
    assign in_pt.x         = s_axis_tdata[31:0];
    assign in_pt.y         = s_axis_tdata[63:32];
    assign in_pt.z         = s_axis_tdata[95:64];
    assign in_pt.speed     = s_axis_tdata[127:96];
    assign in_pt.accel     = s_axis_tdata[159:128];
    assign in_pt.curv      = s_axis_tdata[191:160];
    assign in_pt.curv_rate = s_axis_tdata[223:192];
    assign in_pt.time_v    = s_axis_tdata[255:224];
    assign in_pt.heading   = s_axis_tdata[287:256];
    assign in_pt.arc       = s_axis_tdata[319:288];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = r_ovalid && m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign we = in_acc && in_mode == MODE_APPEND && r_count < CW'(TABLE_DEPTH);
    assign avail = r_count - r_best;
    assign idx = (CW'(r_k) < avail) ? r_best + CW'(r_k) : r_count - CW'(1);
    assign raddr = (r_state == ST_SCAN) ? r_rd[AW-1:0] : idx[AW-1:0];

    npwr_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_count[AW-1:0]), .i_wdata(in_pt),
        .i_raddr(raddr), .o_rdata(rd_pt)
    );

    npwr_dist u_dist (
        .i_clk(i_clk), .i_px(rd_pt.x), .i_py(rd_pt.y),
        .i_qx(r_qx), .i_qy(r_qy), .o_d2(d2)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && in_mode == MODE_QUERY) begin
                    n_state = (r_count < CW'(2)) ? ST_ERR : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd == r_count - CW'(1)) n_state = ST_SCAN_TAIL;
            end
            ST_SCAN_TAIL: begin
                if (r_pipe == 3'b000) n_state = ST_FETCH;
            end
            ST_FETCH: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_ovalid || out_acc) begin
                    n_state = (r_k == r_wlim) ? ST_IDLE : ST_FETCH;
                end
            end
            ST_ERR: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_win    <= WinW'(64);
            r_step   <= StepW'(10000);
            r_ovalid <= 1'b0;
            r_pipe   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WIN) r_win <= i_cfg_data[WinW-1:0];
                else                        r_step <= i_cfg_data[StepW-1:0];
            end
            if (in_acc && in_mode == MODE_CLEAR) r_count <= '0;
            if (in_acc && in_mode == MODE_APPEND) begin
                if (we) r_count <= r_count + CW'(1);
                else    r_ovf <= 1'b1;
            end
            r_pipe <= {r_pipe[1:0], r_state == ST_SCAN};
            if (out_acc) r_ovalid <= 1'b0;
            if (r_state == ST_ERR) r_ovalid <= 1'b1;
            if (r_state == ST_EMIT && (!r_ovalid || out_acc)) r_ovalid <= 1'b1;
        end
    end

    // datapath: scan, best tracking, window emission
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_qx <= in_pt.x;
            r_qy <= in_pt.y;
            r_rd <= '0;
            r_cmp <= '0;
            r_k <= '0;
            r_first <= 1'b1;
            if (r_win == '0) r_wlim <= '0;
            else if (r_win > WinW'(MAX_WINDOW)) r_wlim <= WinW'(MAX_WINDOW - 1);
            else r_wlim <= r_win - WinW'(1);
        end
        if (r_state == ST_SCAN) r_rd <= r_rd + CW'(1);
        if (r_pipe[2]) begin
            r_cmp <= r_cmp + CW'(1);
            if (r_cmp == '0 || d2 < r_best_d) begin
                r_best_d <= d2;
                r_best   <= r_cmp;
            end
        end
        if (r_state == ST_EMIT && (!r_ovalid || out_acc)) begin
            r_opt   <= rd_pt;
            r_olast <= (r_k == r_wlim);
            r_ok    <= 1'b1;
            if (r_first) begin
                r_zero_t <= rd_pt.time_v;
                r_ot <= '0;
                r_t  <= '0;
            end else if (CW'(r_k) < avail) begin
                r_ot <= rd_pt.time_v - r_zero_t;
                r_t  <= rd_pt.time_v - r_zero_t;
            end else begin
                r_ot <= r_t + 32'(r_step);
                r_t  <= r_t + 32'(r_step);
            end
            r_first <= 1'b0;
            r_k <= r_k + WinW'(1);
        end
        if (r_state == ST_ERR) begin
            r_opt   <= '0;
            r_ot    <= '0;
            r_olast <= 1'b1;
            r_ok    <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ok;
    assign m_axis_tdata  = {r_opt.arc, r_opt.heading, r_ot, r_opt.curv_rate,
                            r_opt.curv, r_opt.accel, r_opt.speed, r_opt.z,
                            r_opt.y, r_opt.x};
endmodule

/* hw/rtl/npwr_table.sv */
// Point table: one synchronous memory, one write and one read port.
// Depends on npwr_pkg for the point record type.
module npwr_table import npwr_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_point        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_point        o_rdata
);
    t_point r_mem [TABLE_DEPTH];
    t_point r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/npwr_dist.sv */
// Registered squared planar distance, two register stages.
// Depends on npwr_pkg for nothing beyond house convention.
module npwr_dist import npwr_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_px,
    input  logic [31:0] i_py,
    input  logic [31:0] i_qx,
    input  logic [31:0] i_qy,
    output logic [64:0] o_d2
);
    logic [32:0] r_ax;
    logic [32:0] r_ay;
    logic [63:0] r_sx;
    logic [63:0] r_sy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;

    assign dx = $signed({i_px[31], i_px}) - $signed({i_qx[31], i_qx});
    assign dy = $signed({i_py[31], i_py}) - $signed({i_qy[31], i_qy});

    // absolute differences, then squares, then sum
    always_ff @(posedge i_clk) begin
        r_ax <= dx[32] ? 33'(-dx) : 33'(dx);
        r_ay <= dy[32] ? 33'(-dy) : 33'(dy);
        r_sx <= 64'(r_ax * r_ax);
        r_sy <= 64'(r_ay * r_ay);
    end

    assign o_d2 = {1'b0, r_sx} + {1'b0, r_sy};
endmodule

/* tb/sv/nearest_point_window_replay_tb.sv */
// Self-checking testbench for nearest_point_window_replay.
// Depends on npwr_pkg and the block's RTL; it predicts every result beat from
// its own point table and checks each one as it leaves the block.
`timescale 1ns / 1ps

module nearest_point_window_replay_tb;
    import npwr_pkg::*;

    localparam int TBL_DEPTH  = TableDepthDef;
    localparam int WIN_MAX    = MaxWindowDef;
    localparam int SETTLE     = 16;
    localparam int HOLD_LEN   = 600;
    localparam int CYCLE_CAP  = 1000000;

    // one input beat before packing
    typedef struct {
        t_mode  mode;
        t_point p;
    } t_item;

    // one result beat: ok, last and the ten point fields in tdata order
    typedef struct packed {
        logic             ok;
        logic             last;
        logic [9:0][31:0] f;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [319:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_index = CFG_WIN;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [319:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         o_cfg_ready;

    // pacing knobs, in percent
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    logic         hold_on = 1'b0;

    // predictor state
    t_point       point_tbl [TBL_DEPTH];
    int unsigned  point_cnt = 0;
    logic         table_overflow = 1'b0;
    logic [6:0]   win_len_reg = 7'd64;
    logic [19:0]  step_reg = 20'd10000;
    t_result      window_q [$];

    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;

    string field_name [10] = '{"x", "y", "z", "speed", "accel", "curv", "curv_rate",
                               "time", "heading", "arc"};

    nearest_point_window_replay u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("nearest_point_window_replay_tb: FAIL");
            $finish;
        end
    end

    // output ready: random stall, forced low during a hold-off
    always @(posedge i_clk) begin
        m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // check each result beat against the oldest expectation
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (window_q.size() == 0) begin
                report_mismatch("unexpected beat, tdata[31:0]", m_axis_tdata[31:0], '0);
            end else begin
                want = window_q.pop_front();
                if (m_axis_tuser !== want.ok)
                    report_mismatch("ok", {31'b0, m_axis_tuser}, {31'b0, want.ok});
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", {31'b0, m_axis_tlast}, {31'b0, want.last});
                for (int k = 0; k < 10; k++) begin
                    if (m_axis_tdata[32*k +: 32] !== want.f[k])
                        report_mismatch(field_name[k], m_axis_tdata[32*k +: 32],
                                        want.f[k]);
                end
            end
        end
    end

    function automatic logic [319:0] pack_item(input t_item it);
        logic [319:0] d;
        d = '0;
        d[0 +: 32]   = it.p.x;
        d[32 +: 32]  = it.p.y;
        d[64 +: 32]  = it.p.z;
        d[96 +: 32]  = it.p.speed;
        d[128 +: 32] = it.p.accel;
        d[160 +: 32] = it.p.curv;
        d[192 +: 32] = it.p.curv_rate;
        d[224 +: 32] = it.p.time_v;
        d[256 +: 32] = it.p.heading;
        d[288 +: 32] = it.p.arc;
        return d;
    endfunction

    // exact squared planar distance, wide enough that it never wraps
    function automatic logic [65:0] planar_dist2(input logic [31:0] px, input logic [31:0] py,
                                                 input logic [31:0] qx, input logic [31:0] qy);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [65:0]        ax;
        logic [65:0]        ay;
        dx = $signed({px[31], px}) - $signed({qx[31], qx});
        dy = $signed({py[31], py}) - $signed({qy[31], qy});
        ax = 66'(dx < 0 ? -dx : dx);
        ay = 66'(dy < 0 ? -dy : dy);
        ax[65:33] = '0;
        ay[65:33] = '0;
        return ax * ax + ay * ay;
    endfunction

    // queue the window that a query at (qx, qy) produces
    task automatic predict_window(input logic [31:0] qx, input logic [31:0] qy);
        t_result     r;
        t_point      pt;
        logic [65:0] best_d;
        logic [65:0] d;
        int unsigned best;
        int unsigned win;
        int unsigned idx;
        logic [31:0] t;
        logic [31:0] t0;
        r = '0;
        if (point_cnt < 2) begin
            r.last = 1'b1;
            window_q.insert(window_q.size(), r);
            return;
        end
        best = 0;
        best_d = planar_dist2(point_tbl[0].x, point_tbl[0].y, qx, qy);
        for (int unsigned i = 1; i < point_cnt; i++) begin
            d = planar_dist2(point_tbl[i].x, point_tbl[i].y, qx, qy);
            if (d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        win = (win_len_reg == 0) ? 1 : (win_len_reg > WIN_MAX) ? WIN_MAX : win_len_reg;
        t0 = point_tbl[best].time_v;
        t = '0;
        idx = best;
        for (int unsigned k = 0; k < win; k++) begin
            if (k < point_cnt - best) begin
                idx = best + k;
                t = point_tbl[idx].time_v - t0;
            end else begin
                t = t + {12'b0, step_reg};
            end
            pt = point_tbl[idx];
            r.ok = 1'b1;
            r.last = (k + 1 == win);
            r.f = {pt.arc, pt.heading, t, pt.curv_rate, pt.curv, pt.accel, pt.speed,
                   pt.z, pt.y, pt.x};
            window_q.insert(window_q.size(), r);
        end
    endtask

    // mirror the effect of one accepted beat
    task automatic apply_item(input t_item it);
        case (it.mode)
            MODE_CLEAR: begin
                point_cnt = 0;
            end
            MODE_APPEND: begin
                if (point_cnt >= TBL_DEPTH) begin
                    table_overflow = 1'b1;
                end else begin
                    point_tbl[point_cnt] = it.p;
                    point_cnt++;
                end
            end
            MODE_QUERY: begin
                predict_window(it.p.x, it.p.y);
            end
            default: ;
        endcase
    endtask

    // offer one beat, hold it until taken, then update the predictor
    task automatic send_item(input t_item it);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_item(it);
        s_tuser <= it.mode;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        apply_item(it);
    endtask

    // drop valid, drain every expected beat, let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (window_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic rdy;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIN)
            win_len_reg = value[6:0];
        else
            step_reg = value[19:0];
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(100)) - 50);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_point();
        t_item it;
        it.mode = MODE_APPEND;
        it.p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
        it.p.x = rand_word();
        it.p.y = rand_word();
        it.p.time_v = rand_word();
        return it;
    endfunction

    function automatic t_item make_point(input logic [31:0] v);
        t_item it;
        it.mode = MODE_APPEND;
        it.p = {10{v}};
        return it;
    endfunction

    function automatic t_item make_cmd(input t_mode m, input logic [31:0] qx,
                                       input logic [31:0] qy);
        t_item it;
        it.mode = m;
        it.p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
        it.p.x = qx;
        it.p.y = qy;
        return it;
    endfunction

    // query near a stored point, or anywhere
    function automatic t_item rand_query();
        t_point pt;
        if (point_cnt != 0 && $urandom_range(1)) begin
            pt = point_tbl[$urandom_range(point_cnt - 1)];
            return make_cmd(MODE_QUERY, pt.x + 32'($urandom_range(6)) - 3,
                            pt.y + 32'($urandom_range(6)) - 3);
        end
        return make_cmd(MODE_QUERY, rand_word(), rand_word());
    endfunction

    // error results on short tables, ignored mode
    task automatic test_short_table();
        send_item(make_cmd(MODE_QUERY, 32'h0, 32'h0));
        send_item(make_cmd(MODE_NONE, 32'h1, 32'h1));
        send_item(rand_point());
        send_item(make_cmd(MODE_QUERY, 32'hFFFF_FFFF, 32'h8000_0000));
        send_item(make_cmd(MODE_CLEAR, 32'h0, 32'h0));
        send_item(make_cmd(MODE_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        wait_idle();
    endtask

    // field extremes, ties, wide distances, time wrap and padding
    task automatic test_extremes();
        write_reg(CFG_WIN, 32'd3);
        send_item(make_point(32'h8000_0000));
        send_item(make_point(32'h7FFF_FFFF));
        send_item(make_point(32'h0000_0000));
        send_item(make_point(32'hFFFF_FFFF));
        send_item(make_point(32'h7FFF_FFFF));
        send_item(make_cmd(MODE_QUERY, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_cmd(MODE_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_cmd(MODE_QUERY, 32'h8000_0000, 32'h8000_0000));
        send_item(make_cmd(MODE_QUERY, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_cmd(MODE_QUERY, 32'h0000_0001, 32'h0000_0001));
        wait_idle();
    endtask

    // window and step at their edges, including out-of-range window codes
    task automatic test_register_edges();
        logic [31:0] win_codes [4] = '{32'd0, 32'd127, 32'hFFFF_FF81, 32'd64};
        logic [31:0] step_codes [4] = '{32'd0, 32'd1000000, 32'hFFF0_0001, 32'd1};
        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_WIN, win_codes[i]);
            write_reg(CFG_STEP, step_codes[i]);
            send_item(make_cmd(MODE_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
            send_item(make_cmd(MODE_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        end
        wait_idle();
    endtask

    // short table, then query near its tail so the window pads
    task automatic test_tail_pad();
        write_reg(CFG_WIN, 32'd64);
        send_item(make_cmd(MODE_CLEAR, 32'h0, 32'h0));
        for (int i = 0; i < 10; i++)
            send_item(rand_point());
        send_item(make_cmd(MODE_QUERY, point_tbl[7].x, point_tbl[7].y));
        send_item(make_cmd(MODE_QUERY, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_cmd(MODE_CLEAR, 32'h0, 32'h0));
        send_item(rand_point());
        send_item(rand_point());
        send_item(rand_query());
        wait_idle();
    endtask

    // mostly fill-then-query runs with random content, some noise
    task automatic test_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 7) begin
                if (point_cnt > 60 || $urandom_range(2) == 0) begin
                    send_item(make_cmd(MODE_CLEAR, rand_word(), rand_word()));
                    sent++;
                end
                n = $urandom_range(12, 1);
                repeat (n) send_item(rand_point());
                sent += n;
                n = $urandom_range(3, 1);
                repeat (n) send_item(rand_query());
                sent += n;
            end else begin
                case ($urandom_range(2))
                    0: begin
                        send_item(make_cmd(MODE_NONE, rand_word(), rand_word()));
                        sent++;
                    end
                    1: begin
                        send_item(make_cmd(MODE_CLEAR, rand_word(), rand_word()));
                        if ($urandom_range(1)) begin
                            send_item(rand_point());
                            sent++;
                        end
                        send_item(rand_query());
                        sent += 2;
                    end
                    default: begin
                        send_item(rand_query());
                        sent++;
                    end
                endcase
            end
        end
        wait_idle();
    endtask

    // stall the output long enough that the block stops taking input
    task automatic test_backpressure();
        write_reg(CFG_WIN, 32'd20);
        send_item(make_cmd(MODE_CLEAR, 32'h0, 32'h0));
        repeat (8) send_item(rand_point());
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_on <= 1'b0;
            end
            begin
                repeat (8) send_item(rand_query());
            end
        join
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_short_table();
        test_extremes();
        test_register_edges();
        test_tail_pad();

        // idle phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 82 : (ph == 3) ? 37 : 0;
            recv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 37 : 0;
            write_reg(CFG_WIN, 32'($urandom_range(WIN_MAX, 1)));
            write_reg(CFG_STEP, 32'($urandom_range(1000000)));
            test_random(68);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && window_q.size() == 0) begin
            $display("nearest_point_window_replay_tb: PASS");
        end else begin
            $display("nearest_point_window_replay_tb: FAIL");
        end
        $finish;
    end

endmodule
